>>> rtl/fir_filter_mac_top_assert.svh
// Assertion macros shared by the FIR filter RTL.
`ifndef FIR_FILTER_MAC_TOP_ASSERT_SVH
`define FIR_FILTER_MAC_TOP_ASSERT_SVH

// Same-cycle implication, checked on clk, off during reset.
`define FIRMAC_CHK(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define FIRMAC_CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/firmac_pkg.sv
// Shared constants and types of the FIR filter.
`default_nettype none

package firmac_pkg;

	localparam int MAX_TAPS_DEF = 1025;
	localparam int SAMPLE_BITS  = 24;
	localparam int DATA_W       = 24;
	localparam int OUT_BITS     = (SAMPLE_BITS < DATA_W) ? SAMPLE_BITS : DATA_W;
	localparam int PROD_W       = 2 * DATA_W;
	localparam int CFG_W        = 11;
	localparam int IDX_PORT_W   = 11;
	localparam int FRAC_SHIFT   = 20;

	localparam logic [CFG_W-1:0] TAP_COUNT_RST = 11'd33;

	// item opcodes
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_LOAD   = 1'b1;

	// control that travels with the memory read data into the MAC
	typedef struct packed {
		logic clear;
		logic valid;
		logic live;
	} mac_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/firmac_unit.sv
// Multiply-accumulate unit with round and saturate of the sum.
`default_nettype none

module firmac_unit #(
	parameter int ACC_W = firmac_pkg::PROD_W + 11
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  firmac_pkg::mac_ctrl_t                ctl,
	input  wire signed [firmac_pkg::DATA_W-1:0]  hist,
	input  wire signed [firmac_pkg::DATA_W-1:0]  coef,
	output logic                                 pend,
	output logic       [firmac_pkg::DATA_W-1:0]  rnd_sample,
	output logic                                 rnd_sat
);

	localparam int PW = firmac_pkg::PROD_W;
	localparam int DW = firmac_pkg::DATA_W;
	localparam int OB = firmac_pkg::OUT_BITS;
	localparam int Q_W = ACC_W - firmac_pkg::FRAC_SHIFT;
	localparam logic [ACC_W-1:0] BIAS = ACC_W'(64'd1 << (firmac_pkg::FRAC_SHIFT - 1));
	localparam logic [DW-1:0] SAT_HI = DW'((64'sd1 <<< (OB - 1)) - 64'sd1);
	localparam logic [DW-1:0] SAT_LO = DW'(-(64'sd1 <<< (OB - 1)));

	logic signed [PW-1:0] prod_s2;
	logic                 valid_s2;
	logic [ACC_W-1:0]     acc_q;
	logic [Q_W-1:0]       q;
	logic [Q_W-OB:0]      q_top;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= ctl.valid;
		end
	end

	// taps past the fill count hold the reset zero of the history
	always_ff @(posedge clk) begin
		if (ctl.live) begin
			prod_s2 <= hist * coef;
		end else begin
			prod_s2 <= '0;
		end
		if (ctl.clear) begin
			acc_q <= BIAS;
		end else if (valid_s2) begin
			acc_q <= acc_q + {{(ACC_W-PW){prod_s2[PW-1]}}, prod_s2};
		end
	end

	assign pend = valid_s2;

	// bias was preloaded, so the arithmetic shift rounds half up
	assign q     = acc_q[ACC_W-1:firmac_pkg::FRAC_SHIFT];
	assign q_top = q[Q_W-1:OB-1];

	always_comb begin
		rnd_sat    = !((&q_top) || !(|q_top));
		rnd_sample = q[DW-1:0];
		if (rnd_sat) begin
			rnd_sample = q[Q_W-1] ? SAT_LO : SAT_HI;
		end
	end

endmodule

`default_nettype wire

>>> rtl/fir_filter_mac_top.sv
// Direct-form FIR filter top level: sequencer, tap memories and output register.
//
// One shared multiplier walks the taps, one tap per clock. A coefficient load
// does not stall the input, so the next item may follow at once. A sample holds
// in_stall high while the taps are walked through the single multiply-accumulate
// path with its registered memory reads, the path drains and the result is loaded,
// and longer while an earlier result still waits under out_stall, so no new item
// is taken before the block is through with the last sample. The sample history
// is a circular buffer in memory with a fill count standing in for its reset to
// zero, so no clearing pass follows reset. Coefficients must be loaded before
// samples are filtered. tap_count above MAX_TAPS is treated as MAX_TAPS; a
// finished result waits in the output register while the next item is taken.
`default_nettype none

`include "fir_filter_mac_top_assert.svh"

module fir_filter_mac_top #(
	parameter int MAX_TAPS = firmac_pkg::MAX_TAPS_DEF
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    in_valid,
	output logic                                   in_stall,
	input  wire                                    op,
	input  wire        [firmac_pkg::IDX_PORT_W-1:0] coef_index,
	input  wire signed [firmac_pkg::DATA_W-1:0]    value,
	output logic                                   out_valid,
	input  wire                                    out_stall,
	output logic signed [firmac_pkg::DATA_W-1:0]   filtered_sample,
	output logic                                   saturated,
	input  wire                                    cfg_valid,
	output logic                                   cfg_ready,
	input  wire        [firmac_pkg::CFG_W-1:0]     tap_count
);

	localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int CNT_W = $clog2(MAX_TAPS + 1);
	localparam int ACC_W = firmac_pkg::PROD_W + CNT_W;
	localparam int DW    = firmac_pkg::DATA_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TAPS - 1);
	localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_TAPS);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0]                  state_q;
	logic [firmac_pkg::CFG_W-1:0] tap_count_q;
	logic [IDX_W-1:0]            wptr_q;
	logic [IDX_W-1:0]            rp_q;
	logic [IDX_W-1:0]            j_q;
	logic [CNT_W-1:0]            taps_q;
	logic [CNT_W-1:0]            fill_q;
	logic                        out_valid_q;
	logic [DW-1:0]               filtered_sample_q;
	logic                        saturated_q;

	firmac_pkg::mac_ctrl_t       mac_ctl_s1;
	logic signed [DW-1:0]        hist_s1;
	logic signed [DW-1:0]        coef_s1;

	logic signed [DW-1:0]        hist_mem [MAX_TAPS];
	logic signed [DW-1:0]        coef_mem [MAX_TAPS];

	logic                        in_xfer;
	logic                        smp_acc;
	logic                        ld_acc;
	logic [IDX_W-1:0]            wptr_nx;
	logic [CNT_W-1:0]            taps_in;
	logic                        issue;
	logic                        last_issue;
	logic                        fin_load;
	logic                        mac_pend;
	logic [DW-1:0]               rnd_sample;
	logic                        rnd_sat;

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && !in_stall;
	assign smp_acc   = in_xfer && (op == firmac_pkg::OP_SAMPLE);
	assign ld_acc    = in_xfer && (op == firmac_pkg::OP_LOAD) && (32'(coef_index) < MAX_TAPS);
	assign wptr_nx   = (wptr_q == LAST_IDX) ? '0 : wptr_q + 1'b1;
	assign taps_in   = (32'(tap_count_q) > MAX_TAPS) ? MAX_CNT : CNT_W'(tap_count_q);
	assign issue     = (state_q == ST_RUN);
	assign last_issue = (CNT_W'(j_q) == taps_q - 1'b1);
	assign fin_load  = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tap_count_q <= firmac_pkg::TAP_COUNT_RST;
			wptr_q      <= '0;
			rp_q        <= '0;
			j_q         <= '0;
			taps_q      <= '0;
			fill_q      <= '0;
			mac_ctl_s1  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tap_count_q <= tap_count;
			end

			mac_ctl_s1.clear <= smp_acc;
			mac_ctl_s1.valid <= issue;
			mac_ctl_s1.live  <= issue && (CNT_W'(j_q) < fill_q);

			case (state_q)
				ST_IDLE: begin
					if (smp_acc) begin
						wptr_q <= wptr_nx;
						rp_q   <= wptr_nx;
						j_q    <= '0;
						taps_q <= taps_in;
						if (fill_q != MAX_CNT) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= (taps_in == '0) ? ST_DRAIN : ST_RUN;
					end
				end
				ST_RUN: begin
					rp_q <= (rp_q == '0) ? LAST_IDX : rp_q - 1'b1;
					j_q  <= j_q + 1'b1;
					if (last_issue) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!mac_ctl_s1.valid && !mac_pend) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// tap memories: one write, one registered read each
	always_ff @(posedge clk) begin
		if (smp_acc) begin
			hist_mem[wptr_nx] <= value;
		end
		hist_s1 <= hist_mem[rp_q];
	end

	always_ff @(posedge clk) begin
		if (ld_acc) begin
			coef_mem[coef_index[IDX_W-1:0]] <= value;
		end
		coef_s1 <= coef_mem[j_q];
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			filtered_sample_q <= rnd_sample;
			saturated_q       <= rnd_sat;
		end
	end

	firmac_unit #(
		.ACC_W (ACC_W)
	) u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (mac_ctl_s1),
		.hist       (hist_s1),
		.coef       (coef_s1),
		.pend       (mac_pend),
		.rnd_sample (rnd_sample),
		.rnd_sat    (rnd_sat)
	);

	assign out_valid       = out_valid_q;
	assign filtered_sample = filtered_sample_q;
	assign saturated       = saturated_q;

	`FIRMAC_CHK(a_run_idx, state_q == ST_RUN, CNT_W'(j_q) < taps_q, "tap index past tap count")
	`FIRMAC_CHK(a_fill_max, 1'b1, fill_q <= MAX_CNT, "fill count past history depth")
	`FIRMAC_CHK(a_rp_range, 1'b1, rp_q <= LAST_IDX, "history read pointer out of range")
	`FIRMAC_CHK(a_idle_empty, state_q == ST_IDLE, !mac_ctl_s1.valid && !mac_pend, "MAC busy when idle")
	`FIRMAC_CHK_NEXT(a_fin_out, fin_load, out_valid, "finished result not presented")

endmodule

`default_nettype wire

>>> sim/fir_filter_mac_top_test.sv
// Self-checking testbench of the FIR filter: coefficient loads, samples and tap count changes.
`timescale 1ns / 100ps

module fir_filter_mac_top_test;

	localparam int N_TAPS     = firmac_pkg::MAX_TAPS_DEF;
	localparam int DATA_W     = firmac_pkg::DATA_W;
	localparam int IDX_PORT_W = firmac_pkg::IDX_PORT_W;
	localparam int CFG_W      = firmac_pkg::CFG_W;
	localparam int FRAC_SHIFT = firmac_pkg::FRAC_SHIFT;
	localparam logic signed [DATA_W-1:0] S_MAX = 24'sh7FFFFF;
	localparam logic signed [DATA_W-1:0] S_MIN = 24'sh800000;

	typedef struct {
		logic                     op;
		logic [IDX_PORT_W-1:0]    idx;
		logic signed [DATA_W-1:0] val;
	} fir_item_t;

	typedef struct {
		logic signed [DATA_W-1:0] sample;
		logic                     sat;
	} fir_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic op = firmac_pkg::OP_SAMPLE;
	logic [IDX_PORT_W-1:0] coef_index = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [DATA_W-1:0] filtered_sample;
	logic saturated;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_W-1:0] tap_count = firmac_pkg::TAP_COUNT_RST;

	fir_item_t   stim_items[$];
	fir_result_t filtered_fifo[$];
	fir_item_t   drv_item;

	// filter state as the block should hold it
	logic signed [DATA_W-1:0] hist_q[N_TAPS];
	logic signed [DATA_W-1:0] weight_q[N_TAPS];
	int taps_cfg = firmac_pkg::TAP_COUNT_RST;

	bit weight_planned[N_TAPS];
	int err_count = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;

	fir_filter_mac_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.coef_index(coef_index),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.filtered_sample(filtered_sample),
		.saturated(saturated),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.tap_count(tap_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Apply one accepted item to the filter state; a sample yields one output.
	function automatic void mac_filter_item(fir_item_t it);
		longint acc;
		longint q;
		int n;
		fir_result_t r;
		acc = 0;
		if (it.op == firmac_pkg::OP_LOAD) begin
			if (it.idx < N_TAPS)
				weight_q[it.idx] = it.val;
			return;
		end
		for (int j = N_TAPS - 1; j > 0; j--)
			hist_q[j] = hist_q[j - 1];
		hist_q[0] = it.val;
		n = (taps_cfg > N_TAPS) ? N_TAPS : taps_cfg;
		for (int j = 0; j < n; j++)
			acc += longint'(weight_q[j]) * longint'(hist_q[j]);
		// round half up, then floor by 2^20
		q = (acc + 64'sd524288) >>> FRAC_SHIFT;
		r.sat = 1'b0;
		if (q > longint'(S_MAX)) begin
			q = S_MAX;
			r.sat = 1'b1;
		end else if (q < longint'(S_MIN)) begin
			q = S_MIN;
			r.sat = 1'b1;
		end
		r.sample = q[DATA_W-1:0];
		filtered_fifo.push_back(r);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				mac_filter_item(drv_item);
			if (stim_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				drv_item = stim_items.pop_front();
				op <= drv_item.op;
				coef_index <= drv_item.idx;
				value <= drv_item.val;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		fir_result_t exp_r;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (filtered_fifo.size() == 0) begin
					err_count++;
					$display("%0t: output with none expected: sample %0d sat %0b",
						$time, filtered_sample, saturated);
				end else begin
					exp_r = filtered_fifo.pop_front();
					if (filtered_sample !== exp_r.sample) begin
						err_count++;
						$display("%0t: filtered_sample expected %0d actual %0d",
							$time, exp_r.sample, filtered_sample);
					end
					if (saturated !== exp_r.sat) begin
						err_count++;
						$display("%0t: saturated expected %0b actual %0b",
							$time, exp_r.sat, saturated);
					end
				end
			end
			out_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	function automatic void push_load(logic [IDX_PORT_W-1:0] idx, logic signed [DATA_W-1:0] v);
		fir_item_t it;
		it.op = firmac_pkg::OP_LOAD;
		it.idx = idx;
		it.val = v;
		if (idx < N_TAPS)
			weight_planned[idx] = 1'b1;
		stim_items.push_back(it);
	endfunction

	function automatic void push_sample(logic signed [DATA_W-1:0] v);
		fir_item_t it;
		it.op = firmac_pkg::OP_SAMPLE;
		it.idx = IDX_PORT_W'($urandom);
		it.val = v;
		stim_items.push_back(it);
	endfunction

	// full-scale weights saturate often, so mostly scale them down
	function automatic logic signed [DATA_W-1:0] rand_weight();
		logic signed [DATA_W-1:0] w;
		w = DATA_W'($urandom);
		return w >>> $urandom_range(0, 12);
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_sample();
		case ($urandom_range(9))
			0: return S_MAX;
			1: return S_MIN;
			2: return ($urandom_range(1) != 0) ? 24'sd0 : -24'sd1;
			default: return DATA_W'($urandom);
		endcase
	endfunction

	// no sample may read a tap weight that was never loaded
	function automatic void ensure_weights(int n);
		for (int i = 0; i < n && i < N_TAPS; i++)
			if (!weight_planned[i])
				push_load(IDX_PORT_W'(i), rand_weight());
	endfunction

	function automatic void push_random(int count, int taps_eff);
		logic [IDX_PORT_W-1:0] idx;
		repeat (count) begin
			if ($urandom_range(99) < 30) begin
				if ($urandom_range(9) == 0 || taps_eff == 0)
					idx = IDX_PORT_W'($urandom);
				else
					idx = IDX_PORT_W'($urandom_range(0, taps_eff - 1));
				push_load(idx, rand_weight());
			end else begin
				push_sample(rand_sample());
			end
		end
	endfunction

	task automatic wait_drained();
		while (stim_items.size() != 0 || in_valid || filtered_fifo.size() != 0)
			@(posedge clk);
		// loads leave no result behind, give the last one time to settle
		repeat (10) @(posedge clk);
	endtask

	task automatic set_taps(input int n);
		wait_drained();
		tap_count <= CFG_W'(n);
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		taps_cfg = n;
	endtask

	initial begin
		int n;
		for (int i = 0; i < N_TAPS; i++) begin
			hist_q[i] = '0;
			weight_q[i] = '0;
		end
		tx_idle_pct = 6;
		rx_stall_pct = 82;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unit gain on tap 0 passes samples straight through
		push_load(11'd0, 24'sh100000);
		for (int i = 1; i < 33; i++)
			push_load(IDX_PORT_W'(i), '0);
		push_load(11'd1024, rand_weight());
		push_load(11'd1025, S_MAX);
		push_load(11'd2047, S_MIN);
		push_sample(S_MAX);
		push_sample(S_MIN);
		push_sample(24'sd0);
		push_sample(-24'sd1);
		// extreme weights drive the sum out of range both ways
		push_load(11'd1, S_MAX);
		push_load(11'd2, S_MIN);
		push_sample(S_MAX);
		push_sample(S_MAX);
		push_sample(S_MIN);
		push_sample(S_MIN);
		// smallest weight: exactly half an output LSB rounds up
		push_load(11'd1, '0);
		push_load(11'd2, '0);
		push_load(11'd0, 24'sd1);
		push_sample(24'sh080000);
		push_sample(24'sh07FFFF);
		push_sample(-24'sh080000);
		push_sample(-24'sh080001);
		push_random(150, 33);

		set_taps(0);
		push_random(20, 0);
		set_taps(1);
		push_random(40, 1);

		tx_idle_pct = 82;
		rx_stall_pct = 6;
		n = 2 * $urandom_range(16, 64) + 1;
		set_taps(n);
		ensure_weights(n);
		push_random(150, n);

		tx_idle_pct = 0;
		rx_stall_pct = 0;
		set_taps(33);
		push_random(60, 33);
		wait_drained();
		push_random(60, 33);

		wait_drained();
		repeat (50) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/firmac_pkg.sv
rtl/firmac_unit.sv
rtl/fir_filter_mac_top.sv
sim/fir_filter_mac_top_test.sv
